// ----- design/sap_pkg.sv -----
// ---------------------------------------------------------------------------
// sap_pkg: shared types and constants of the shelf atlas packer
// Opcodes, status codes, register indexes and the entry and store control
// records used across the packer modules.
// ---------------------------------------------------------------------------
package sap_pkg;

  localparam int RECT_W    = 12;  // padded rectangle side
  localparam int PAD_W     = 4;   // atlas padding
  localparam int CFG_W     = 13;  // widest configuration register
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_H = 2'd2;

  localparam logic [PAD_W-1:0] PAD_RST       = 4'd1;
  localparam logic [CFG_W-1:0] INIT_SIDE_RST = 13'd256;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_MAX_SIZE  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [RECT_W-1:0] tw;
    logic [RECT_W-1:0] th;
    logic              empty;
  } rect_t;

  typedef struct packed {
    logic ent_we;
    logic pos_we;
    logic rd_en;
  } store_ctl_t;

endpackage

// ----- design/sap_alu.sv -----
// ---------------------------------------------------------------------------
// sap_alu: shared three-operand adder and limit compare
// Every placement and growth step of the packer goes through this unit.
// ---------------------------------------------------------------------------
module sap_alu #(
  parameter int CW = 15
) (
  input  logic [CW-1:0] a,
  input  logic [CW-1:0] b,
  input  logic [CW-1:0] c,
  input  logic [CW-1:0] lim,
  output logic [CW-1:0] sum,
  output logic          gt
);

  logic [CW+1:0] full_sum;

  assign full_sum = (CW+2)'(a) + (CW+2)'(b) + (CW+2)'(c);
  assign sum      = full_sum[CW-1:0];
  assign gt       = full_sum > (CW+2)'(lim);

endmodule

// ----- design/sap_store.sv -----
// ---------------------------------------------------------------------------
// sap_store: entry and position memories
// Entry sizes in one memory, positions in a two-bank memory so a repack
// can be dropped without touching the live positions.
// ---------------------------------------------------------------------------
module sap_store #(
  parameter int DEPTH = 256,
  parameter int SW    = 13,
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic                clk,
  input  sap_pkg::store_ctl_t ctl,
  input  logic [IW-1:0]       wr_idx,
  input  logic                wr_bank,
  input  sap_pkg::rect_t      ent_wdata,
  input  logic [SW-1:0]       pos_wx,
  input  logic [SW-1:0]       pos_wy,
  input  logic [IW-1:0]       rd_idx,
  input  logic                rd_bank,
  output sap_pkg::rect_t      ent_rdata,
  output logic [SW-1:0]       pos_rx,
  output logic [SW-1:0]       pos_ry
);

  sap_pkg::rect_t    ent_mem [0:DEPTH-1];
  logic [2*SW-1:0]   pos_mem [0:(2**(IW+1))-1];
  logic [2*SW-1:0]   pos_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      ent_mem[wr_idx] <= ent_wdata;
    end
    if (ctl.pos_we) begin
      pos_mem[{wr_bank, wr_idx}] <= {pos_wx, pos_wy};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      ent_rdata <= ent_mem[rd_idx];
      pos_rd_r  <= pos_mem[{rd_bank, rd_idx}];
    end
  end

  assign pos_rx = pos_rd_r[2*SW-1:SW];
  assign pos_ry = pos_rd_r[SW-1:0];

endmodule

// ----- design/sap_seq.sv -----
// ---------------------------------------------------------------------------
// sap_seq: packer sequencer
// Runs add, query and clear requests step by step, placing adds over the shared
// adder; grows the atlas and walks the store for a repack, holds the result.
// ---------------------------------------------------------------------------
module sap_seq #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_SIDE    = 4096,
  localparam int IW   = $clog2(MAX_ENTRIES),
  localparam int CNTW = $clog2(MAX_ENTRIES + 1),
  localparam int SW   = $clog2(MAX_SIDE + 1),
  localparam int CW   = ((SW > sap_pkg::RECT_W + 1) ? SW : sap_pkg::RECT_W + 1) + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [IW-1:0]                     in_entry_index,
  input  logic [sap_pkg::RECT_W-1:0]        in_pad_width,
  input  logic [sap_pkg::RECT_W-1:0]        in_pad_height,
  input  logic                              in_is_empty,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [SW-1:0]                     out_pos_x,
  output logic [SW-1:0]                     out_pos_y,
  output logic [SW-1:0]                     out_atlas_width,
  output logic [SW-1:0]                     out_atlas_height,
  output logic                              out_repacked,
  output logic [IW-1:0]                     out_assigned_index,
  output logic [2:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sap_pkg::CFG_W-1:0]         cfg_data,
  output sap_pkg::store_ctl_t               st_ctl,
  output logic [IW-1:0]                     st_wr_idx,
  output logic                              st_wr_bank,
  output sap_pkg::rect_t                    st_ent_wdata,
  output logic [SW-1:0]                     st_pos_wx,
  output logic [SW-1:0]                     st_pos_wy,
  output logic [IW-1:0]                     st_rd_idx,
  output logic                              st_rd_bank,
  input  sap_pkg::rect_t                    st_ent_rdata,
  input  logic [SW-1:0]                     st_pos_rx,
  input  logic [SW-1:0]                     st_pos_ry,
  output logic [CW-1:0]                     alu_a,
  output logic [CW-1:0]                     alu_b,
  output logic [CW-1:0]                     alu_c,
  output logic [CW-1:0]                     alu_lim,
  input  logic [CW-1:0]                     alu_sum,
  input  logic                              alu_gt
);

  localparam int CMPW = SW + sap_pkg::CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_RD, S_ROW, S_NROW, S_FIT, S_ADV, S_GROW, S_OUT
  } state_t;

  function automatic logic [SW-1:0] clamp_side(input logic [sap_pkg::CFG_W-1:0] v);
    logic [CMPW-1:0] ext;
    ext = CMPW'(v);
    if (v == '0) begin
      return SW'(1);
    end else if (ext > CMPW'(MAX_SIDE)) begin
      return SW'(MAX_SIDE);
    end else begin
      return SW'(ext);
    end
  endfunction

  state_t                        state_r, state_nxt;
  logic [sap_pkg::PAD_W-1:0]     pad_r, pad_nxt;
  logic [sap_pkg::CFG_W-1:0]     initw_r, initw_nxt;
  logic [sap_pkg::CFG_W-1:0]     inith_r, inith_nxt;

  // committed packer state
  logic [CNTW-1:0]               count_r, count_nxt;
  logic [CW-1:0]                 cx_r, cx_nxt;
  logic [CW-1:0]                 cy_r, cy_nxt;
  logic [sap_pkg::RECT_W-1:0]    rh_r, rh_nxt;
  logic [SW-1:0]                 w_r, w_nxt;
  logic [SW-1:0]                 h_r, h_nxt;
  logic                          bank_r, bank_nxt;

  // working copy while an add is in flight
  logic [CW-1:0]                 wcx_r, wcx_nxt;
  logic [CW-1:0]                 wcy_r, wcy_nxt;
  logic [sap_pkg::RECT_W-1:0]    wrh_r, wrh_nxt;
  logic [SW-1:0]                 ww_r, ww_nxt;
  logic [SW-1:0]                 wh_r, wh_nxt;
  logic                          rep_r, rep_nxt;
  logic [IW-1:0]                 ridx_r, ridx_nxt;
  sap_pkg::rect_t                rect_r, rect_nxt;
  logic [IW-1:0]                 qidx_r, qidx_nxt;

  // result waiting for the output register
  logic [SW-1:0]                 res_x_r, res_x_nxt;
  logic [SW-1:0]                 res_y_r, res_y_nxt;
  logic                          res_rep_r, res_rep_nxt;
  logic [IW-1:0]                 res_aidx_r, res_aidx_nxt;
  sap_pkg::status_t              res_st_r, res_st_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [SW-1:0]                 out_x_r, out_x_nxt;
  logic [SW-1:0]                 out_y_r, out_y_nxt;
  logic [SW-1:0]                 out_w_r, out_w_nxt;
  logic [SW-1:0]                 out_h_r, out_h_nxt;
  logic                          out_rep_r, out_rep_nxt;
  logic [IW-1:0]                 out_aidx_r, out_aidx_nxt;
  sap_pkg::status_t              out_st_r, out_st_nxt;

  sap_pkg::opcode_t              in_op;
  sap_pkg::rect_t                cur_rect;
  logic                          accept;
  logic                          full;
  logic                          last_ent;
  logic [IW-1:0]                 cur_idx;
  logic [CW-1:0]                 pad_cw;
  logic [CW-1:0]                 pad2_cw;
  logic [SW-1:0]                 grow_side;
  logic [sap_pkg::RECT_W-1:0]    new_rh;

  assign in_op     = sap_pkg::opcode_t'(in_opcode);
  assign cur_rect  = rep_r ? st_ent_rdata : rect_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign full      = (count_r == CNTW'(MAX_ENTRIES));
  assign last_ent  = (ridx_r == count_r[IW-1:0]);
  assign cur_idx   = rep_r ? ridx_r : count_r[IW-1:0];
  assign pad_cw    = CW'(pad_r);
  assign pad2_cw   = {pad_cw[CW-2:0], 1'b0};
  assign grow_side = (ww_r == wh_r) ? ww_r : wh_r;
  assign new_rh    = (cur_rect.th > wrh_r) ? cur_rect.th : wrh_r;

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pos_x          = out_x_r;
  assign out_pos_y          = out_y_r;
  assign out_atlas_width    = out_w_r;
  assign out_atlas_height   = out_h_r;
  assign out_repacked       = out_rep_r;
  assign out_assigned_index = out_aidx_r;
  assign out_status         = out_st_r;

  // store port steering
  assign st_rd_idx    = (state_r == S_RD) ? ridx_r : in_entry_index;
  assign st_rd_bank   = bank_r;
  assign st_wr_idx    = (state_r == S_ADV) ? cur_idx : count_r[IW-1:0];
  assign st_wr_bank   = rep_r ? ~bank_r : bank_r;
  assign st_ent_wdata = '{tw: in_pad_width, th: in_pad_height, empty: in_is_empty};
  assign st_pos_wx    = wcx_r[SW-1:0];
  assign st_pos_wy    = wcy_r[SW-1:0];

  always_comb begin
    st_ctl        = '0;
    st_ctl.ent_we = accept && (in_op == sap_pkg::OP_ADD) && !full;
    st_ctl.pos_we = (state_r == S_ADV);
    st_ctl.rd_en  = (state_r == S_RD) || (accept && (in_op == sap_pkg::OP_QUERY));
  end

  // operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_c   = '0;
    alu_lim = '0;
    case (state_r)
      S_ROW: begin
        alu_a   = wcx_r;
        alu_b   = CW'(cur_rect.tw);
        alu_c   = pad2_cw;
        alu_lim = CW'(ww_r);
      end
      S_NROW: begin
        alu_a = wcy_r;
        alu_b = CW'(wrh_r);
        alu_c = pad_cw;
      end
      S_FIT: begin
        alu_a   = wcy_r;
        alu_b   = CW'(cur_rect.th);
        alu_c   = pad2_cw;
        alu_lim = CW'(wh_r);
      end
      S_ADV: begin
        alu_a = wcx_r;
        alu_b = CW'(cur_rect.tw);
        alu_c = pad_cw;
      end
      S_GROW: begin
        alu_a   = CW'({grow_side, 1'b0});
        alu_lim = CW'(MAX_SIDE);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pad_nxt       = pad_r;
    initw_nxt     = initw_r;
    inith_nxt     = inith_r;
    count_nxt     = count_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rh_nxt        = rh_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    bank_nxt      = bank_r;
    wcx_nxt       = wcx_r;
    wcy_nxt       = wcy_r;
    wrh_nxt       = wrh_r;
    ww_nxt        = ww_r;
    wh_nxt        = wh_r;
    rep_nxt       = rep_r;
    ridx_nxt      = ridx_r;
    rect_nxt      = rect_r;
    qidx_nxt      = qidx_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_rep_nxt   = res_rep_r;
    res_aidx_nxt  = res_aidx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_w_nxt     = out_w_r;
    out_h_nxt     = out_h_r;
    out_rep_nxt   = out_rep_r;
    out_aidx_nxt  = out_aidx_r;
    out_st_nxt    = out_st_r;

    if (cfg_we) begin
      case (cfg_index)
        sap_pkg::CFG_PAD:    pad_nxt   = cfg_data[sap_pkg::PAD_W-1:0];
        sap_pkg::CFG_INIT_W: initw_nxt = cfg_data;
        sap_pkg::CFG_INIT_H: inith_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_x_nxt    = '0;
          res_y_nxt    = '0;
          res_rep_nxt  = 1'b0;
          res_aidx_nxt = '0;
          res_st_nxt   = sap_pkg::ST_OK;
          rect_nxt     = st_ent_wdata;
          qidx_nxt     = in_entry_index;
          state_nxt    = S_OUT;
          case (in_op)
            sap_pkg::OP_ADD: begin
              if (full) begin
                res_st_nxt = sap_pkg::ST_FULL;
              end else if (in_is_empty) begin
                count_nxt    = count_r + CNTW'(1);
                res_aidx_nxt = count_r[IW-1:0];
                res_st_nxt   = sap_pkg::ST_EMPTY;
              end else begin
                wcx_nxt   = cx_r;
                wcy_nxt   = cy_r;
                wrh_nxt   = rh_r;
                ww_nxt    = w_r;
                wh_nxt    = h_r;
                rep_nxt   = 1'b0;
                state_nxt = S_ROW;
              end
            end
            sap_pkg::OP_QUERY: begin
              state_nxt = S_QRD;
            end
            sap_pkg::OP_CLEAR: begin
              count_nxt = '0;
              cx_nxt    = pad_cw;
              cy_nxt    = pad_cw;
              rh_nxt    = '0;
              w_nxt     = clamp_side(initw_r);
              h_nxt     = clamp_side(inith_r);
            end
            default: begin
            end
          endcase
        end
      end

      S_QRD: begin
        res_aidx_nxt = qidx_r;
        if (CNTW'(qidx_r) >= count_r) begin
          res_st_nxt = sap_pkg::ST_BAD_INDEX;
        end else if (st_ent_rdata.empty) begin
          res_st_nxt = sap_pkg::ST_EMPTY;
        end else begin
          res_x_nxt = st_pos_rx;
          res_y_nxt = st_pos_ry;
        end
        state_nxt = S_OUT;
      end

      S_RD: begin
        state_nxt = S_ROW;
      end

      S_ROW: begin
        if (rep_r && cur_rect.empty) begin
          // empty glyphs keep no position, step over them
          ridx_nxt  = ridx_r + IW'(1);
          state_nxt = S_RD;
        end else if (alu_gt) begin
          state_nxt = S_NROW;
        end else begin
          state_nxt = S_FIT;
        end
      end

      S_NROW: begin
        wcx_nxt   = pad_cw;
        wcy_nxt   = alu_sum;
        wrh_nxt   = '0;
        state_nxt = S_FIT;
      end

      S_FIT: begin
        state_nxt = alu_gt ? S_GROW : S_ADV;
      end

      S_ADV: begin
        if (!rep_r || last_ent) begin
          count_nxt    = count_r + CNTW'(1);
          cx_nxt       = alu_sum;
          cy_nxt       = wcy_r;
          rh_nxt       = new_rh;
          w_nxt        = ww_r;
          h_nxt        = wh_r;
          bank_nxt     = bank_r ^ rep_r;
          res_x_nxt    = wcx_r[SW-1:0];
          res_y_nxt    = wcy_r[SW-1:0];
          res_rep_nxt  = rep_r;
          res_aidx_nxt = count_r[IW-1:0];
          res_st_nxt   = sap_pkg::ST_OK;
          state_nxt    = S_OUT;
        end else begin
          wcx_nxt   = alu_sum;
          wrh_nxt   = new_rh;
          ridx_nxt  = ridx_r + IW'(1);
          state_nxt = S_RD;
        end
      end

      S_GROW: begin
        if (alu_gt) begin
          // size limit hit: nothing of this add is committed
          res_st_nxt = sap_pkg::ST_MAX_SIZE;
          state_nxt  = S_OUT;
        end else begin
          if (ww_r == wh_r) begin
            ww_nxt = {ww_r[SW-2:0], 1'b0};
          end else begin
            wh_nxt = {wh_r[SW-2:0], 1'b0};
          end
          wcx_nxt   = pad_cw;
          wcy_nxt   = pad_cw;
          wrh_nxt   = '0;
          ridx_nxt  = '0;
          rep_nxt   = 1'b1;
          state_nxt = S_RD;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_w_nxt     = w_r;
          out_h_nxt     = h_r;
          out_rep_nxt   = res_rep_r;
          out_aidx_nxt  = res_aidx_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    wcx_r      <= wcx_nxt;
    wcy_r      <= wcy_nxt;
    wrh_r      <= wrh_nxt;
    ww_r       <= ww_nxt;
    wh_r       <= wh_nxt;
    rep_r      <= rep_nxt;
    ridx_r     <= ridx_nxt;
    rect_r     <= rect_nxt;
    qidx_r     <= qidx_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_rep_r  <= res_rep_nxt;
    res_aidx_r <= res_aidx_nxt;
    res_st_r   <= res_st_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_w_r    <= out_w_nxt;
    out_h_r    <= out_h_nxt;
    out_rep_r  <= out_rep_nxt;
    out_aidx_r <= out_aidx_nxt;
    out_st_r   <= out_st_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pad_r       <= sap_pkg::PAD_RST;
      initw_r     <= sap_pkg::INIT_SIDE_RST;
      inith_r     <= sap_pkg::INIT_SIDE_RST;
      count_r     <= '0;
      cx_r        <= CW'(sap_pkg::PAD_RST);
      cy_r        <= CW'(sap_pkg::PAD_RST);
      rh_r        <= '0;
      w_r         <= clamp_side(sap_pkg::INIT_SIDE_RST);
      h_r         <= clamp_side(sap_pkg::INIT_SIDE_RST);
      bank_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pad_r       <= pad_nxt;
      initw_r     <= initw_nxt;
      inith_r     <= inith_nxt;
      count_r     <= count_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      rh_r        <= rh_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      bank_r      <= bank_nxt;
    end
  end

endmodule

// ----- design/shelf_atlas_packer_top.sv -----
// ---------------------------------------------------------------------------
// shelf_atlas_packer_top: shelf packer for a texture atlas
// Places padded rectangles in rows, grows the atlas and repacks on overflow.
// ---------------------------------------------------------------------------
// usage
//   in_* channel takes one request per handshake (valid high, stall low):
//   add a rectangle, query an entry's position, or clear the store. every
//   request gives exactly one result on the out_* channel.
//   cfg_* is a plain write port for padding and the initial atlas size;
//   write it only while the packer is idle.
// sequencing
//   clear / unused opcode: the result goes straight to the output register
//   query: registered memory read, then the result
//   add without growth: row check, optional new row, fit check, advance,
//   result; the checks and the advance share one adder and compare
//   add with growth: a doubling step, then a repack pass over every stored
//   rectangle (read, row check, optional new row, fit check, advance; an empty glyph only read and row check)
//   a new request is taken in the cycle after the result is registered
// reset: synchronous, active low; store empty, atlas at 256 x 256,
//   padding 1, cursors at the padding
// stall: the result waits in the output register; the packer still takes
//   the next request and holds its result until the register frees up
// ---------------------------------------------------------------------------
module shelf_atlas_packer_top #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_SIDE    = 4096,
  localparam int IW = $clog2(MAX_ENTRIES),
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int CW = ((SW > sap_pkg::RECT_W + 1) ? SW : sap_pkg::RECT_W + 1) + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [IW-1:0]                 in_entry_index,
  input  logic [sap_pkg::RECT_W-1:0]    in_pad_width,
  input  logic [sap_pkg::RECT_W-1:0]    in_pad_height,
  input  logic                          in_is_empty,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SW-1:0]                 out_pos_x,
  output logic [SW-1:0]                 out_pos_y,
  output logic [SW-1:0]                 out_atlas_width,
  output logic [SW-1:0]                 out_atlas_height,
  output logic                          out_repacked,
  output logic [IW-1:0]                 out_assigned_index,
  output logic [2:0]                    out_status,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sap_pkg::CFG_W-1:0]     cfg_data
);

  // sequencer to store
  sap_pkg::store_ctl_t st_ctl;
  logic [IW-1:0]       st_wr_idx;
  logic                st_wr_bank;
  sap_pkg::rect_t      st_ent_wdata;
  logic [SW-1:0]       st_pos_wx;
  logic [SW-1:0]       st_pos_wy;
  logic [IW-1:0]       st_rd_idx;
  logic                st_rd_bank;
  sap_pkg::rect_t      st_ent_rdata;
  logic [SW-1:0]       st_pos_rx;
  logic [SW-1:0]       st_pos_ry;

  // sequencer to shared adder
  logic [CW-1:0]       alu_a;
  logic [CW-1:0]       alu_b;
  logic [CW-1:0]       alu_c;
  logic [CW-1:0]       alu_lim;
  logic [CW-1:0]       alu_sum;
  logic                alu_gt;

  // control: add / query / clear sequencing, growth and repack walk
  sap_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_SIDE    (MAX_SIDE)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_entry_index     (in_entry_index),
    .in_pad_width       (in_pad_width),
    .in_pad_height      (in_pad_height),
    .in_is_empty        (in_is_empty),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_atlas_width    (out_atlas_width),
    .out_atlas_height   (out_atlas_height),
    .out_repacked       (out_repacked),
    .out_assigned_index (out_assigned_index),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .st_ctl             (st_ctl),
    .st_wr_idx          (st_wr_idx),
    .st_wr_bank         (st_wr_bank),
    .st_ent_wdata       (st_ent_wdata),
    .st_pos_wx          (st_pos_wx),
    .st_pos_wy          (st_pos_wy),
    .st_rd_idx          (st_rd_idx),
    .st_rd_bank         (st_rd_bank),
    .st_ent_rdata       (st_ent_rdata),
    .st_pos_rx          (st_pos_rx),
    .st_pos_ry          (st_pos_ry),
    .alu_a              (alu_a),
    .alu_b              (alu_b),
    .alu_c              (alu_c),
    .alu_lim            (alu_lim),
    .alu_sum            (alu_sum),
    .alu_gt             (alu_gt)
  );

  // sizes and flags per entry, positions in two banks (live and repack)
  sap_store #(
    .DEPTH (MAX_ENTRIES),
    .SW    (SW)
  ) u_store (
    .clk       (clk),
    .ctl       (st_ctl),
    .wr_idx    (st_wr_idx),
    .wr_bank   (st_wr_bank),
    .ent_wdata (st_ent_wdata),
    .pos_wx    (st_pos_wx),
    .pos_wy    (st_pos_wy),
    .rd_idx    (st_rd_idx),
    .rd_bank   (st_rd_bank),
    .ent_rdata (st_ent_rdata),
    .pos_rx    (st_pos_rx),
    .pos_ry    (st_pos_ry)
  );

  // one adder with limit compare, reused by every placement step
  sap_alu #(
    .CW (CW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .lim (alu_lim),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  // an entry is written only by an add request taken in that cycle
  a_ent_write_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctl.ent_we |-> (in_valid && !in_stall &&
                       (in_opcode == sap_pkg::OP_ADD)))
    else $error("entry write without an accepted add");

  // positions are written only while a request is in work
  a_pos_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctl.pos_we |-> in_stall)
    else $error("position write while idle");

  // a new result only follows a cycle with a request in work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in work");

  // a repacked result is always a successful add
  a_repack_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_repacked) |-> (out_status == sap_pkg::ST_OK))
    else $error("repack flag on a failed result");

endmodule
